[rtl/bfgs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfgs_pkg
// Shared types, request codes and saturation helpers for the BFGS
// inverse-Hessian update block.
// ----------------------------------------------------------------------------
package bfgs_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // request codes
  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] REQ_LOAD_VEC   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE    = 2'd2;
  localparam logic [1:0] REQ_READ       = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO_SY = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam logic signed [63:0] SAT_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN64 = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [5:0]               row;
    logic [5:0]               col;
    logic signed [DATA_W-1:0] matrix_value;
    logic signed [DATA_W-1:0] coord_new;
    logic signed [DATA_W-1:0] coord_prev;
    logic signed [DATA_W-1:0] grad_new;
    logic signed [DATA_W-1:0] grad_prev;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic                     sat;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX64) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN64) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] x);
    return (x > SAT_MAX64) || (x < SAT_MIN64);
  endfunction

  function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage
`default_nettype wire

[rtl/bfgs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfgs channel interfaces
// Valid/ready channels for requests, results and the size register.
// ----------------------------------------------------------------------------
interface bfgs_req_if import bfgs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bfgs_rsp_if import bfgs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bfgs_cfg_if import bfgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/bfgs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfgs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign rdata = rd_r;

endmodule
`default_nettype wire

[rtl/bfgs_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfgs_div
// Serial fixed-point divider: sat((num << FRAC_BITS) / den), truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfgs_div import bfgs_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(32'h8000_0000);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r, q_r;
  logic [31:0]      rem_r, den_r;

  logic [32:0] na, nb, rem_sh, rem_diff;
  logic        ge, over;
  logic [31:0] q_lo;

  always_comb begin
    na       = req.num[31] ? (33'd0 - {req.num[31], req.num}) : {1'b0, req.num};
    nb       = req.den[31] ? (33'd0 - {req.den[31], req.den}) : {1'b0, req.den};
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = !rem_diff[32];
    over     = neg_r ? (q_r > NEG_LIM) : (q_r > POS_LIM);
    q_lo     = q_r[31:0];
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.sat  = over;
    if (over) begin
      rsp.quo = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp.quo = neg_r ? (32'd0 - q_lo) : q_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= {na[31:0], {FRAC_BITS{1'b0}}};
      den_r <= nb[31:0];
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= req.num[31] ^ req.den[31];
    end else if (busy_r) begin
      rem_r <= ge ? rem_diff[31:0] : rem_sh[31:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
      num_r <= num_r << 1;
    end
  end

endmodule
`default_nettype wire

[rtl/bfgs_inverse_hessian_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfgs_inverse_hessian_update
// In-place BFGS update of an N x N inverse Hessian held in block RAM,
// signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        beat when
//  in_bus    in   req_type,row,col,matrix_value,coords,grads     valid & ready
//  out_bus   out  read_value,status (one beat per request)       valid & ready
//  cfg_bus   in   active_size                                    valid & ready
//
//  Loads and reads: one beat per cycle unless out_bus back-pressure holds the
//  result path; each result goes through p1, then the output register.
//  Compute: the row/column products stream through one multiplier, one term a
//  cycle; each entry update waits on the serial divider, a quotient bit a cycle.
//  No request is taken while a compute runs; cfg is always ready.
//  Reset clears control and sets N to 64; the stores are not cleared.
// ----------------------------------------------------------------------------
module bfgs_inverse_hessian_update import bfgs_pkg::*; #(
  parameter int MAX_COORDS = 64,
  parameter int FRAC_BITS  = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  bfgs_req_if.sink   in_bus,
  bfgs_rsp_if.source out_bus,
  bfgs_cfg_if.sink   cfg_bus
);

  localparam int IDX_W  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_COORDS + 1);
  localparam int HA_W   = 2 * IDX_W;
  localparam int VDEPTH = 1 << IDX_W;
  localparam int HDEPTH = 1 << HA_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DOT     = 4'd1;
  localparam logic [3:0] S_SCAL    = 4'd2;
  localparam logic [3:0] S_R_WAIT  = 4'd3;
  localparam logic [3:0] S_C1_WAIT = 4'd4;
  localparam logic [3:0] S_E_RD    = 4'd5;
  localparam logic [3:0] S_E_M1    = 4'd6;
  localparam logic [3:0] S_E_M2    = 4'd7;
  localparam logic [3:0] S_E_M3    = 4'd8;
  localparam logic [3:0] S_E_M4    = 4'd9;
  localparam logic [3:0] S_E_T1    = 4'd10;
  localparam logic [3:0] S_E_DIV   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  localparam logic [1:0] PH_U  = 2'd0;
  localparam logic [1:0] PH_V  = 2'd1;
  localparam logic [1:0] PH_SY = 2'd2;
  localparam logic [1:0] PH_YU = 2'd3;

  // control
  logic [3:0]        state_r;
  logic [1:0]        phase_r;
  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  n_r;
  logic [IDX_W-1:0]  i_r, j_r, rd_i_r, pr_i_r;
  logic              iss_end_r, rd_vld_r, rd_last_r, pr_vld_r, pr_last_r;
  logic              zero_r, sat_r;
  logic [1:0]        last_status_r;
  logic              p1_valid_r, p1_rd_r;
  logic [1:0]        p1_status_r;
  logic              out_valid_r;
  rsp_t              out_data_r;
  logic [IDX_W-1:0]  last_row_r, last_col_r;

  // datapath
  logic signed [63:0] acc_r, prod_r, p2_r;
  logic signed [31:0] sy_r, yu_r, c1_r, si_r, sj_r, ui_r, vj_r, hv_r, a_r, t1_r;

  // ram ports
  logic [HA_W-1:0]  h_raddr, h_waddr;
  logic             h_we, vec_we, u_we, v_we;
  logic [31:0]      h_wdata, h_rdata, sa_rdata, sb_rdata, y_rdata, u_rdata, v_rdata;
  logic [IDX_W-1:0] sa_raddr, u_raddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  req_t               req;
  logic               in_fire, row_ok, col_ok, p1_adv, done_fire;
  logic [IDX_W-1:0]   row_i, col_i;
  logic [32:0]        ds, dy;
  logic               ds_sat, dy_sat;
  logic signed [31:0] s_val, y_val, mul_a, mul_b, acc_sat, b_sat, opr_sat, h_new;
  logic signed [63:0] pf, acc_sum, b_sum, opr_sum, h_sum;
  logic               single, last_k, last_i;
  logic [CNT_W-1:0]   n_w;
  logic [1:0]         cmp_status;

  assign req       = in_bus.data;
  assign row_ok    = 32'(req.row) < 32'(MAX_COORDS);
  assign col_ok    = 32'(req.col) < 32'(MAX_COORDS);
  assign row_i     = IDX_W'(req.row);
  assign col_i     = IDX_W'(req.col);
  assign p1_adv    = p1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = (state_r == S_IDLE) && (!p1_valid_r || p1_adv);
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign done_fire = (state_r == S_DONE) && (!p1_valid_r || p1_adv);
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  assign n_w = (32'(size_r) > 32'(MAX_COORDS)) ? CNT_W'(MAX_COORDS) : CNT_W'(size_r);
  assign cmp_status = zero_r ? ST_ZERO_SY : (sat_r ? ST_SAT : ST_OK);

  // vector load differences
  always_comb begin
    ds     = {req.coord_new[31], req.coord_new} - {req.coord_prev[31], req.coord_prev};
    dy     = {req.grad_new[31], req.grad_new} - {req.grad_prev[31], req.grad_prev};
    ds_sat = ds[32] ^ ds[31];
    dy_sat = dy[32] ^ dy[31];
    s_val  = ds_sat ? (ds[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : ds[31:0];
    y_val  = dy_sat ? (dy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dy[31:0];
  end

  // shared arithmetic
  always_comb begin
    pf      = prod_r >>> FRAC_BITS;
    acc_sum = acc_r + pf;
    acc_sat = sat32(acc_sum);
    b_sum   = p2_r + pf;
    b_sat   = sat32(b_sum);
    opr_sum = (64'sd1 <<< FRAC_BITS) + sx64(div_rsp.quo);
    opr_sat = sat32(opr_sum);
    h_sum   = sx64(hv_r) + sx64(t1_r) - sx64(div_rsp.quo);
    h_new   = sat32(h_sum);
    // the scalar dot passes run a single row; the entry loop walks all rows
    single  = (state_r == S_DOT) && ((phase_r == PH_SY) || (phase_r == PH_YU));
    last_k  = (CNT_W'(j_r) + CNT_W'(1)) == n_r;
    last_i  = single || ((CNT_W'(i_r) + CNT_W'(1)) == n_r);
  end

  // multiplier operands
  always_comb begin
    mul_a = c1_r;
    mul_b = a_r;
    case (state_r)
      S_DOT: begin
        case (phase_r)
          PH_SY: begin
            mul_a = sa_rdata;
            mul_b = y_rdata;
          end
          PH_YU: begin
            mul_a = y_rdata;
            mul_b = u_rdata;
          end
          default: begin
            mul_a = h_rdata;
            mul_b = y_rdata;
          end
        endcase
      end
      S_E_M1: begin
        mul_a = sa_rdata;
        mul_b = sb_rdata;
      end
      S_E_M2: begin
        mul_a = si_r;
        mul_b = vj_r;
      end
      S_E_M3: begin
        mul_a = ui_r;
        mul_b = sj_r;
      end
      default: begin
        mul_a = c1_r;
        mul_b = a_r;
      end
    endcase
  end

  // memory addressing
  always_comb begin
    case (state_r)
      S_IDLE:  h_raddr = in_fire ? {row_i, col_i} : {last_row_r, last_col_r};
      S_DOT:   h_raddr = (phase_r == PH_V) ? {j_r, i_r} : {i_r, j_r};
      default: h_raddr = {i_r, j_r};
    endcase
    sa_raddr = (state_r == S_DOT) ? j_r : i_r;
    u_raddr  = (state_r == S_DOT) ? j_r : i_r;
    h_we     = (in_fire && req.req_type == REQ_LOAD_ENTRY && row_ok && col_ok)
            || (state_r == S_E_DIV && div_rsp.done);
    h_waddr  = (state_r == S_IDLE) ? {row_i, col_i} : {i_r, j_r};
    h_wdata  = (state_r == S_IDLE) ? req.matrix_value : h_new;
    vec_we   = in_fire && req.req_type == REQ_LOAD_VEC && row_ok;
    u_we     = (state_r == S_DOT) && pr_vld_r && pr_last_r && (phase_r == PH_U);
    v_we     = (state_r == S_DOT) && pr_vld_r && pr_last_r && (phase_r == PH_V);
  end

  // divider requests
  always_comb begin
    div_req.start = ((state_r == S_SCAL) && (sy_r != '0))
                 || ((state_r == S_R_WAIT) && div_rsp.done)
                 || (state_r == S_E_M4);
    div_req.den   = sy_r;
    case (state_r)
      S_SCAL:   div_req.num = yu_r;
      S_R_WAIT: div_req.num = opr_sat;
      default:  div_req.num = b_sat;
    endcase
  end

  bfgs_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_h_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));
  // step vector is held twice so s_i and s_j are read in the same cycle
  bfgs_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_sa_ram (
    .clk(clk), .we(vec_we), .waddr(row_i), .wdata(s_val),
    .raddr(sa_raddr), .rdata(sa_rdata));
  bfgs_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_sb_ram (
    .clk(clk), .we(vec_we), .waddr(row_i), .wdata(s_val),
    .raddr(j_r), .rdata(sb_rdata));
  bfgs_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_y_ram (
    .clk(clk), .we(vec_we), .waddr(row_i), .wdata(y_val),
    .raddr(j_r), .rdata(y_rdata));
  bfgs_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_u_ram (
    .clk(clk), .we(u_we), .waddr(pr_i_r), .wdata(acc_sat),
    .raddr(u_raddr), .rdata(u_rdata));
  bfgs_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_v_ram (
    .clk(clk), .we(v_we), .waddr(pr_i_r), .wdata(acc_sat),
    .raddr(j_r), .rdata(v_rdata));

  bfgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_U;
      size_r        <= SIZE_RESET;
      iss_end_r     <= 1'b0;
      rd_vld_r      <= 1'b0;
      pr_vld_r      <= 1'b0;
      zero_r        <= 1'b0;
      sat_r         <= 1'b0;
      last_status_r <= ST_OK;
      p1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        size_r <= cfg_bus.data;
      end

      // result path: p1 then output register
      if (in_fire && req.req_type != REQ_COMPUTE) begin
        p1_valid_r <= 1'b1;
      end else if (done_fire) begin
        p1_valid_r <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= 1'b0;
      pr_vld_r <= (state_r == S_DOT) && rd_vld_r;

      case (state_r)
        S_IDLE: begin
          if (in_fire && req.req_type == REQ_COMPUTE) begin
            sat_r     <= 1'b0;
            phase_r   <= PH_U;
            iss_end_r <= 1'b0;
            if (n_w == '0) begin
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              zero_r  <= 1'b0;
              state_r <= S_DOT;
            end
          end
        end
        S_DOT: begin
          if (!iss_end_r) begin
            rd_vld_r <= 1'b1;
            if (last_k && last_i) begin
              iss_end_r <= 1'b1;
            end
          end
          if (pr_vld_r && pr_last_r) begin
            sat_r <= sat_r | sat_hit(acc_sum);
          end
          if (iss_end_r && !rd_vld_r && !pr_vld_r) begin
            iss_end_r <= 1'b0;
            if (phase_r == PH_YU) begin
              state_r <= S_SCAL;
            end else begin
              phase_r <= phase_r + 2'd1;
            end
          end
        end
        S_SCAL: begin
          if (sy_r == '0) begin
            zero_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_R_WAIT;
          end
        end
        S_R_WAIT: begin
          if (div_rsp.done) begin
            sat_r   <= sat_r | div_rsp.sat | sat_hit(opr_sum);
            state_r <= S_C1_WAIT;
          end
        end
        S_C1_WAIT: begin
          if (div_rsp.done) begin
            sat_r   <= sat_r | div_rsp.sat;
            state_r <= S_E_RD;
          end
        end
        S_E_RD: state_r <= S_E_M1;
        S_E_M1: state_r <= S_E_M2;
        S_E_M2: begin
          sat_r   <= sat_r | sat_hit(pf);
          state_r <= S_E_M3;
        end
        S_E_M3: state_r <= S_E_M4;
        S_E_M4: begin
          sat_r   <= sat_r | sat_hit(b_sum);
          state_r <= S_E_T1;
        end
        S_E_T1: begin
          sat_r   <= sat_r | sat_hit(pf);
          state_r <= S_E_DIV;
        end
        S_E_DIV: begin
          if (div_rsp.done) begin
            sat_r <= sat_r | div_rsp.sat | sat_hit(h_sum);
            if (last_k && last_i) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_E_RD;
            end
          end
        end
        S_DONE: begin
          if (done_fire) begin
            last_status_r <= cmp_status;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (in_fire) begin
      last_row_r <= row_i;
      last_col_r <= col_i;
      p1_rd_r    <= (req.req_type == REQ_READ) && row_ok && col_ok;
      case (req.req_type)
        REQ_LOAD_VEC: p1_status_r <= (ds_sat || dy_sat) ? ST_SAT : ST_OK;
        REQ_READ:     p1_status_r <= last_status_r;
        default:      p1_status_r <= ST_OK;
      endcase
    end else if (done_fire) begin
      p1_rd_r     <= 1'b0;
      p1_status_r <= cmp_status;
    end
    if (p1_adv) begin
      out_data_r.read_value <= p1_rd_r ? h_rdata : '0;
      out_data_r.status     <= p1_status_r;
    end

    rd_last_r <= last_k;
    rd_i_r    <= i_r;
    pr_last_r <= rd_last_r;
    pr_i_r    <= rd_i_r;

    case (state_r)
      S_IDLE: begin
        n_r   <= n_w;
        i_r   <= '0;
        j_r   <= '0;
        acc_r <= '0;
      end
      S_DOT: begin
        if (!iss_end_r) begin
          if (last_k) begin
            j_r <= '0;
            if (!last_i) begin
              i_r <= i_r + IDX_W'(1);
            end
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
        if (pr_vld_r) begin
          if (pr_last_r) begin
            acc_r <= '0;
            if (phase_r == PH_SY) begin
              sy_r <= acc_sat;
            end
            if (phase_r == PH_YU) begin
              yu_r <= acc_sat;
            end
          end else begin
            acc_r <= acc_sum;
          end
        end
        if (iss_end_r && !rd_vld_r && !pr_vld_r) begin
          i_r <= '0;
          j_r <= '0;
        end
      end
      S_C1_WAIT: begin
        if (div_rsp.done) begin
          c1_r <= div_rsp.quo;
          i_r  <= '0;
          j_r  <= '0;
        end
      end
      S_E_M1: begin
        si_r <= sa_rdata;
        sj_r <= sb_rdata;
        ui_r <= u_rdata;
        vj_r <= v_rdata;
        hv_r <= h_rdata;
      end
      S_E_M2: a_r  <= sat32(pf);
      S_E_M3: p2_r <= pf;
      S_E_T1: t1_r <= sat32(pf);
      S_E_DIV: begin
        if (div_rsp.done) begin
          if (last_k) begin
            j_r <= '0;
            i_r <= i_r + IDX_W'(1);
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // u and v must see the old matrix: nothing writes it during the dot passes
  a_no_h_write_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOT) |-> !h_we)
    else $error("matrix written during dot pass");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOT && iss_end_r && !rd_vld_r && !pr_vld_r) |-> (acc_r == '0))
    else $error("accumulator not cleared at end of pass");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE) |=> !(p1_valid_r && !$past(p1_valid_r)))
    else $error("result produced mid-compute");

endmodule
`default_nettype wire

[tb/tb_bfgs_inverse_hessian_update.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bfgs_inverse_hessian_update
// Self-checking bench for the BFGS inverse-Hessian update block. A directed
// table with a few hand-read results precedes random phases at several matrix
// sizes. Other result beats are checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_bfgs_inverse_hessian_update;
  import bfgs_pkg::*;

  localparam int NDIR = 21;
  localparam int FB   = 20;

  logic clk;
  logic rst_n;

  bfgs_req_if req_bus();
  bfgs_rsp_if rsp_bus();
  bfgs_cfg_if cfg_bus();

  bfgs_inverse_hessian_update dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (req_bus),
    .out_bus (rsp_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  int          hmat [4096];
  int          step_v [64];
  int          gdiff_v [64];
  int          hy_v [64];
  int          yh_v [64];
  logic [1:0]  last_st;
  int unsigned size_reg;
  bit          sat_seen;
  bit          h_written [4096];
  bit          v_written [64];

  rsp_t expected_rsp [$];
  int   err_count;
  bit   quiet;
  int   rsp_hold;

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(x);
  endfunction

  function automatic longint qmul(int a, int b);
    return (longint'(a) * longint'(b)) >>> FB;
  endfunction

  function automatic longint qdiv(int a, int b);
    return (longint'(a) <<< FB) / longint'(b);
  endfunction

  function automatic logic [1:0] bfgs_update();
    int     n;
    longint acc;
    int     sy, yu, r, c1, a, t1, b, t2;
    n = (size_reg < 64) ? size_reg : 64;
    sat_seen = 1'b0;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < n; k++) acc += qmul(hmat[i*64+k], gdiff_v[k]);
      hy_v[i] = clamp32(acc);
      acc = 0;
      for (int k = 0; k < n; k++) acc += qmul(gdiff_v[k], hmat[k*64+i]);
      yh_v[i] = clamp32(acc);
    end
    acc = 0;
    for (int k = 0; k < n; k++) acc += qmul(step_v[k], gdiff_v[k]);
    sy = clamp32(acc);
    acc = 0;
    for (int k = 0; k < n; k++) acc += qmul(gdiff_v[k], hy_v[k]);
    yu = clamp32(acc);
    if (sy == 0) return ST_ZERO_SY;
    r  = clamp32(qdiv(yu, sy));
    c1 = clamp32(qdiv(clamp32((longint'(1) <<< FB) + longint'(r)), sy));
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        a  = clamp32(qmul(step_v[i], step_v[j]));
        t1 = clamp32(qmul(c1, a));
        b  = clamp32(qmul(step_v[i], yh_v[j]) + qmul(hy_v[i], step_v[j]));
        t2 = clamp32(qdiv(b, sy));
        hmat[i*64+j] = clamp32(longint'(hmat[i*64+j]) + longint'(t1) - longint'(t2));
      end
    end
    return sat_seen ? ST_SAT : ST_OK;
  endfunction

  function automatic rsp_t predict_rsp(req_t q);
    rsp_t o;
    int   s, y;
    o.read_value = '0;
    o.status     = ST_OK;
    case (q.req_type)
      REQ_LOAD_ENTRY: hmat[q.row*64+q.col] = q.matrix_value;
      REQ_LOAD_VEC: begin
        sat_seen = 1'b0;
        s = clamp32(longint'(q.coord_new) - longint'(q.coord_prev));
        y = clamp32(longint'(q.grad_new) - longint'(q.grad_prev));
        step_v[q.row]  = s;
        gdiff_v[q.row] = y;
        o.status = sat_seen ? ST_SAT : ST_OK;
      end
      REQ_COMPUTE: begin
        o.status = bfgs_update();
        last_st  = o.status;
      end
      default: begin
        o.read_value = hmat[q.row*64+q.col];
        o.status     = last_st;
      end
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] t, int r, int c, int mv,
                                  int cn, int cp, int gn, int gp);
    req_t q;
    q.req_type = t;  q.row = r[5:0]; q.col = c[5:0];
    q.matrix_value = mv; q.coord_new = cn; q.coord_prev = cp;
    q.grad_new = gn; q.grad_prev = gp;
    return q;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result side: random stalls, check against oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rsp_hold = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected beat", rsp_bus.data.read_value, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_bus.data.read_value !== want.read_value)
            report_mismatch("read_value", rsp_bus.data.read_value, want.read_value);
          if (rsp_bus.data.status !== want.status)
            report_mismatch("status", rsp_bus.data.status, want.status);
        end
        rsp_hold = quiet ? 0 : $urandom_range(0, 3);
      end else if (rsp_hold != 0) begin
        rsp_hold--;
      end
      rsp_bus.ready <= (rsp_hold == 0);
    end
  end

  task automatic send_req(req_t q, bit fixed, rsp_t fixed_rsp);
    int   gap;
    rsp_t p;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= q;
    do @(posedge clk); while (!req_bus.ready);
    p = predict_rsp(q);
    expected_rsp.push_back(fixed ? fixed_rsp : p);
    if (q.req_type == REQ_LOAD_ENTRY) h_written[q.row*64+q.col] = 1'b1;
    if (q.req_type == REQ_LOAD_VEC) v_written[q.row] = 1'b1;
  endtask

  // stop offering the last beat, then wait for every result
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(int unsigned sz);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= sz[6:0];
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    size_reg = sz & 7'h7F;
  endtask

  function automatic int rand_val(bit wide);
    if (wide) return int'($urandom);
    return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  task automatic random_req(int n, bit may_compute);
    int   pick, r, c;
    bit   wide;
    rsp_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    r = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n-1) : $urandom_range(0, 63);
    c = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n-1) : $urandom_range(0, 63);
    if (pick < 30) begin
      send_req(mk_req(REQ_LOAD_ENTRY, r, c, rand_val(wide), rand_val(1), rand_val(1),
                      rand_val(1), rand_val(1)), 1'b0, none);
    end else if (pick < 55) begin
      send_req(mk_req(REQ_LOAD_VEC, r, c, rand_val(1), rand_val(wide), rand_val(wide),
                      rand_val(wide), rand_val(wide)), 1'b0, none);
    end else if (pick < 65 && may_compute) begin
      send_req(mk_req(REQ_COMPUTE, r, c, rand_val(1), rand_val(1), rand_val(1),
                      rand_val(1), rand_val(1)), 1'b0, none);
    end else begin
      if (!h_written[r*64+c]) begin
        r = 0;
        c = 0;
      end
      send_req(mk_req(REQ_READ, r, c, rand_val(1), rand_val(1), rand_val(1),
                      rand_val(1), rand_val(1)), 1'b0, none);
    end
  endtask

  req_t dir_req [NDIR];
  bit   dir_chk [NDIR];
  rsp_t dir_exp [NDIR];

  initial begin
    int unsigned sizes [8];
    int n, items;
    rsp_t none;
    sizes = '{1, 3, 0, 4, 64, 127, 6, 2};
    none  = '0;
    rst_n = 1'b0;
    req_bus.valid = 1'b0; req_bus.data = '0;
    cfg_bus.valid = 1'b0; cfg_bus.data = '0;
    rsp_bus.ready = 1'b0;
    err_count = 0; quiet = 1'b0; rsp_hold = 0;
    last_st = ST_OK; size_reg = SIZE_RESET;
    foreach (hmat[i]) begin hmat[i] = 0; h_written[i] = 1'b0; end
    for (int i = 0; i < 64; i++) begin
      step_v[i] = 0; gdiff_v[i] = 0; hy_v[i] = 0; yh_v[i] = 0; v_written[i] = 1'b0;
    end

    dir_req[0]  = mk_req(REQ_LOAD_ENTRY, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    dir_req[1]  = mk_req(REQ_LOAD_ENTRY, 0, 1, 32'h8000_0000, 0, 0, 0, 0);
    dir_req[2]  = mk_req(REQ_LOAD_ENTRY, 1, 0, 0, 0, 0, 0, 0);
    dir_req[3]  = mk_req(REQ_LOAD_ENTRY, 1, 1, 1 << FB, 0, 0, 0, 0);
    dir_req[4]  = mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    dir_req[5]  = mk_req(REQ_READ, 0, 1, 0, 0, 0, 0, 0);
    dir_req[6]  = mk_req(REQ_LOAD_VEC, 0, 0, 0, 0, 0, 0, 0);
    dir_req[7]  = mk_req(REQ_LOAD_VEC, 1, 0, 0, 0, 0, 0, 0);
    dir_req[8]  = mk_req(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
    dir_req[9]  = mk_req(REQ_READ, 1, 1, 0, 0, 0, 0, 0);
    dir_req[10] = mk_req(REQ_LOAD_VEC, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000);
    dir_req[11] = mk_req(REQ_LOAD_VEC, 1, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF);
    dir_req[12] = mk_req(REQ_LOAD_VEC, 0, 0, 0, 1 << FB, 0, 1 << FB, 0);
    dir_req[13] = mk_req(REQ_LOAD_VEC, 1, 0, 0, 2 << FB, 0, 1 << (FB-1), 0);
    dir_req[14] = mk_req(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
    dir_req[15] = mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    dir_req[16] = mk_req(REQ_READ, 0, 1, 0, 0, 0, 0, 0);
    dir_req[17] = mk_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
    dir_req[18] = mk_req(REQ_READ, 1, 1, 0, 0, 0, 0, 0);
    dir_req[19] = mk_req(REQ_LOAD_ENTRY, 63, 63, -1, 0, 0, 0, 0);
    dir_req[20] = mk_req(REQ_READ, 63, 63, 0, 0, 0, 0, 0);
    foreach (dir_chk[i]) begin dir_chk[i] = 1'b0; dir_exp[i] = '0; end
    dir_chk[0] = 1'b1; dir_chk[1] = 1'b1; dir_chk[2] = 1'b1; dir_chk[3] = 1'b1;
    dir_chk[4] = 1'b1; dir_exp[4].read_value = 32'h7FFF_FFFF;
    dir_chk[5] = 1'b1; dir_exp[5].read_value = 32'h8000_0000;
    dir_chk[6] = 1'b1; dir_chk[7] = 1'b1;
    dir_chk[8] = 1'b1; dir_exp[8].status = ST_ZERO_SY;
    dir_chk[9] = 1'b1; dir_exp[9].read_value = 1 << FB; dir_exp[9].status = ST_ZERO_SY;
    dir_chk[10] = 1'b1; dir_exp[10].status = ST_SAT;
    dir_chk[11] = 1'b1; dir_exp[11].status = ST_SAT;
    dir_chk[12] = 1'b1; dir_chk[13] = 1'b1; dir_chk[19] = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(2);
    for (int i = 0; i < NDIR; i++) send_req(dir_req[i], dir_chk[i], dir_exp[i]);

    for (int p = 0; p < 8; p++) begin
      drain();
      @(posedge clk);
      quiet = (p == 3);
      write_size(sizes[p]);
      n = (sizes[p] < 64) ? sizes[p] : 64;
      // every entry a compute touches must hold a written value
      if (n < 64) begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            if (!h_written[i*64+j])
              send_req(mk_req(REQ_LOAD_ENTRY, i, j, rand_val(0), 0, 0, 0, 0), 1'b0, none);
        for (int k = 0; k < n; k++)
          if (!v_written[k])
            send_req(mk_req(REQ_LOAD_VEC, k, 0, 0, rand_val(0), rand_val(0),
                            rand_val(0), rand_val(0)), 1'b0, none);
      end
      items = (n >= 64) ? 80 : 260;
      for (int it = 0; it < items; it++) begin
        if (p == 2 && it == 100) begin
          drain();
        end
        random_req(n, n < 64);
      end
    end
    quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("bfgs_inverse_hessian_update regression: pass");
    end else begin
      $display("bfgs_inverse_hessian_update regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bfgs_inverse_hessian_update regression: fail");
    $finish;
  end

endmodule
